/* sv/fbsc_pkg.sv */
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared codes and types for the framed byte shift cipher receiver.
// ----------------------------------------------------------------------------
package fbsc_pkg;

  // stream opcodes
  localparam logic [7:0] OP_ENCRYPT = 8'd0;
  localparam logic [7:0] OP_DECRYPT = 8'd1;
  localparam logic [7:0] OP_FRAME   = 8'd2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EOF     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // one classified result waiting for the back end
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;     // raw payload byte, zero otherwise
    logic [7:0]  key;
    logic        decrypt;
    logic [31:0] total;    // session total on end of file, zero otherwise
  } entry_t;

  // front end to queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

/* sv/fbsc_front.sv */
// ----------------------------------------------------------------------------
// fbsc_front
// Session and frame parser: tracks header, length and payload phases and
// queues one classified result per byte that produces one.
// ----------------------------------------------------------------------------
module fbsc_front
  import fbsc_pkg::*;
#(
  parameter int LENGTH_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output push_t      push
);

  localparam logic [2:0] PH_SESS_OP   = 3'd0;
  localparam logic [2:0] PH_SESS_LEN  = 3'd1;
  localparam logic [2:0] PH_SESS_KEY  = 3'd2;
  localparam logic [2:0] PH_FRAME_OP  = 3'd3;
  localparam logic [2:0] PH_FRAME_LEN = 3'd4;
  localparam logic [2:0] PH_PAYLOAD   = 3'd5;

  localparam logic [2:0] LEN_LAST = 3'(LENGTH_BYTES);

  logic [2:0]  phase, phase_next;
  logic [2:0]  count, count_next;
  logic        decrypt, decrypt_next;
  logic [7:0]  key, key_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] total, total_next;
  logic [2:0]  count_inc;

  assign count_inc = count + 3'd1;

  always_comb begin
    phase_next        = phase;
    count_next        = count;
    decrypt_next      = decrypt;
    key_next          = key;
    length_shift_next = length_shift;
    payload_left_next = payload_left;
    total_next        = total;
    push              = '0;
    push.entry.key     = key;
    push.entry.decrypt = decrypt;
    if (accept) begin
      case (phase)
        PH_SESS_LEN: begin
          count_next = count_inc;
          if (count_inc >= LEN_LAST) phase_next = PH_SESS_KEY;
        end
        PH_SESS_KEY: begin
          key_next   = in_byte;
          phase_next = PH_FRAME_OP;
        end
        PH_FRAME_OP: begin
          if (in_byte != OP_FRAME) begin
            phase_next      = PH_SESS_OP;
            push.valid      = 1'b1;
            push.entry.kind = KIND_ERROR;
          end else begin
            count_next        = '0;
            length_shift_next = '0;
            phase_next        = PH_FRAME_LEN;
          end
        end
        PH_FRAME_LEN: begin
          length_shift_next = {length_shift[23:0], in_byte};
          count_next        = count_inc;
          if (count_inc >= LEN_LAST) begin
            if (length_shift_next == '0) begin
              phase_next       = PH_SESS_OP;
              push.valid       = 1'b1;
              push.entry.kind  = KIND_EOF;
              push.entry.total = total;
            end else begin
              payload_left_next = length_shift_next;
              phase_next        = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          push.valid        = 1'b1;
          push.entry.kind   = KIND_PAYLOAD;
          push.entry.data   = in_byte;
          total_next        = total + 32'd1;
          payload_left_next = payload_left - 32'd1;
          if (payload_left == 32'd1) phase_next = PH_FRAME_OP;
        end
        default: begin
          // session opcode; unused phase codes land here as well
          if (in_byte != OP_ENCRYPT && in_byte != OP_DECRYPT) begin
            phase_next      = PH_SESS_OP;
            push.valid      = 1'b1;
            push.entry.kind = KIND_ERROR;
          end else begin
            decrypt_next = (in_byte == OP_DECRYPT);
            total_next   = '0;
            count_next   = '0;
            phase_next   = PH_SESS_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SESS_OP;
      count        <= '0;
      decrypt      <= 1'b0;
      key          <= '0;
      length_shift <= '0;
      payload_left <= '0;
      total        <= '0;
    end else begin
      phase        <= phase_next;
      count        <= count_next;
      decrypt      <= decrypt_next;
      key          <= key_next;
      length_shift <= length_shift_next;
      payload_left <= payload_left_next;
      total        <= total_next;
    end
  end

endmodule

/* sv/fbsc_fifo.sv */
// ----------------------------------------------------------------------------
// fbsc_fifo
// Short result queue between parser and output stage.
// ----------------------------------------------------------------------------
module fbsc_fifo
  import fbsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  push_t                      push,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level,
  output entry_t                     head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/fbsc_back.sv */
// ----------------------------------------------------------------------------
// fbsc_back
// Output stage: applies the byte shift and holds the result register.
// ----------------------------------------------------------------------------
module fbsc_back
  import fbsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  entry_t      head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser
);

  logic [7:0] shifted;

  assign pop     = !empty && (!m_tvalid || m_tready);
  assign shifted = head.decrypt ? head.data - head.key : head.data + head.key;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tuser <= head.kind;
      m_tdata <= {head.total, (head.kind == KIND_PAYLOAD) ? shifted : 8'd0};
    end
  end

endmodule

/* sv/framed_byte_shift_cipher_receiver.sv */
// ----------------------------------------------------------------------------
// framed_byte_shift_cipher_receiver
// Deframes a session byte stream and shifts payload bytes by the session key.
// ----------------------------------------------------------------------------
// One byte is taken per cycle on s_* while the queue is not full, with results
// leaving on m_* one per cycle while m_tready is high. A byte passes the parser
// in the cycle it is taken, sits in a FIFO_DEPTH-entry queue, and leaves
// through the output register. s_tready drops only while the queue is full,
// which takes FIFO_DEPTH + 1 result-producing bytes under a stalled m_tready
// (one of them waits in the output register). Payload bytes, end of file and
// protocol errors produce exactly one result each; other header and length
// bytes produce none.
module framed_byte_shift_cipher_receiver
  import fbsc_pkg::*;
#(
  parameter int LENGTH_BYTES = 4,
  parameter int FIFO_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] total_bytes
  output logic [1:0]  m_tuser    // [1:0] result_kind
);

  push_t  push;
  entry_t head;
  logic   full, empty, pop, accept;
  logic [$clog2(FIFO_DEPTH+1)-1:0] level;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  fbsc_front #(.LENGTH_BYTES(LENGTH_BYTES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_tdata),
    .push    (push)
  );

  fbsc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .level (level),
    .head  (head)
  );

  fbsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH))
    else $error("result queue over depth");

  // a result never finds the queue full
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("result pushed into full queue");

  // only end of file carries a total
  a_total_only_eof: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_EOF) |-> (m_tdata[39:8] == 32'd0))
    else $error("total on non end-of-file result");

  // non-payload results carry a zero byte
  a_byte_only_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'd0))
    else $error("data byte on non-payload result");
`endif

endmodule
